// ===== rtl/utf8_pkg.sv =====
// Shared types, constants and byte-class helpers for the UTF-8 stream decoder.
package utf8_pkg;

    localparam int unsigned CP_W   = 21;
    localparam int unsigned BYTE_W = 8;

    localparam logic [BYTE_W-1:0] ASCII_LIMIT = 8'h80;
    localparam logic [BYTE_W-1:0] LEAD2_MASK  = 8'hE0;
    localparam logic [BYTE_W-1:0] LEAD2_CODE  = 8'hC0;
    localparam logic [BYTE_W-1:0] LEAD3_MASK  = 8'hF0;
    localparam logic [BYTE_W-1:0] LEAD3_CODE  = 8'hE0;
    localparam logic [BYTE_W-1:0] LEAD4_MASK  = 8'hF8;
    localparam logic [BYTE_W-1:0] LEAD4_CODE  = 8'hF0;
    localparam logic [BYTE_W-1:0] LEAD2_BITS  = 8'h1F;
    localparam logic [BYTE_W-1:0] LEAD3_BITS  = 8'h0F;
    localparam logic [BYTE_W-1:0] LEAD4_BITS  = 8'h07;
    localparam logic [BYTE_W-1:0] CONT_BITS   = 8'h3F;

    // One decoded result as it waits in the output buffer.
    typedef struct packed {
        logic [CP_W-1:0] code_point;
        logic            bad_sequence;
        logic            run_last;
    } res_t;

    // Lead byte class: number of following bytes (0 = not a lead) and payload.
    typedef struct packed {
        logic [1:0]      extra;
        logic [CP_W-1:0] bits;
    } lead_t;

    function automatic lead_t lead_class(input logic [BYTE_W-1:0] b);
        lead_t l;
        l.extra = 2'd0;
        l.bits  = '0;
        priority if ((b & LEAD2_MASK) == LEAD2_CODE)
        begin
            l.extra = 2'd1;
            l.bits  = {{(CP_W-BYTE_W){1'b0}}, b & LEAD2_BITS};
        end
        else if ((b & LEAD3_MASK) == LEAD3_CODE)
        begin
            l.extra = 2'd2;
            l.bits  = {{(CP_W-BYTE_W){1'b0}}, b & LEAD3_BITS};
        end
        else if ((b & LEAD4_MASK) == LEAD4_CODE)
        begin
            l.extra = 2'd3;
            l.bits  = {{(CP_W-BYTE_W){1'b0}}, b & LEAD4_BITS};
        end
        else
        begin
            l.extra = 2'd0;
        end
        return l;
    endfunction

    // A lone byte decoded as a whole text: ASCII passes, anything else is bad.
    function automatic res_t single_byte(input logic [BYTE_W-1:0] b);
        res_t r;
        r.run_last = 1'b0;
        if (b < ASCII_LIMIT)
        begin
            r.code_point   = {{(CP_W-BYTE_W){1'b0}}, b};
            r.bad_sequence = 1'b0;
        end
        else
        begin
            r.code_point   = '0;
            r.bad_sequence = 1'b1;
        end
        return r;
    endfunction

    // Append six payload bits of a following byte to a partial code point.
    function automatic logic [CP_W-1:0] shift_in(input logic [CP_W-1:0] acc,
                                                 input logic [BYTE_W-1:0] b);
        logic [BYTE_W-1:0] low;
        low = b & CONT_BITS;
        return {acc[CP_W-7:0], low[5:0]};
    endfunction

endpackage

// ===== rtl/utf8_stream_decoder_unit.sv =====
// UTF-8 stream decoder: one text byte in, zero to three code points out.
//
//  channel  | dir | tdata                  | tuser         | tlast
//  ---------+-----+------------------------+---------------+------------
//  s_axis   | in  | [7:0] text_byte        | -             | end_of_text
//  m_axis   | out | [20:0] code_point, pad | bad_sequence  | run_last
//
// One text byte is taken per cycle and its results are registered in the
// same cycle, so the common case (ASCII, completed sequence, bad lead)
// runs at one item per clock while m_axis_tready stays high.
// A sequence cut off by the end of the text yields two or three results;
// those drain one per cycle from the three-entry result buffer while
// m_axis_tready is high; the input waits while more than the last remains.
// rst_n clears the decode state and empties the result buffer.
// m_axis_tready low holds the buffer; s_axis_tready drops while two or more
// results wait, or while one waits and m_axis_tready is low.
module utf8_stream_decoder_unit
    import utf8_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] text_byte
    input  logic        s_axis_tlast,   // end_of_text
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // [20:0] code_point, [23:21] zero
    output logic        m_axis_tuser,   // [0] bad_sequence
    output logic        m_axis_tlast    // run_last
);

    // Decode state; the lead byte itself is never read back, so only the
    // first following byte is held.
    logic [1:0]        need_reg, need_next;
    logic [CP_W-1:0]   part_reg, part_next;
    logic [BYTE_W-1:0] held1_reg, held1_next;
    logic [1:0]        held_cnt_reg, held_cnt_next;

    // Result buffer, head in slot 0
    res_t              slot_reg [3];
    res_t              slot_next [3];
    logic [1:0]        out_cnt_reg, out_cnt_next;

    // Results of the byte on the input port
    res_t              res [3];
    logic [1:0]        res_n;

    logic              in_take;
    logic              out_take;
    logic [BYTE_W-1:0] b;
    logic              eot;
    lead_t             lead;
    lead_t             lead1;
    logic [CP_W-1:0]   pv;
    logic [1:0]        nd;

    assign b    = s_axis_tdata;
    assign eot  = s_axis_tlast;
    assign lead = lead_class(b);
    assign lead1 = lead_class(held1_reg);
    assign pv   = shift_in(part_reg, b);
    assign nd   = need_reg - 2'd1;

    assign m_axis_tvalid = (out_cnt_reg != 2'd0);
    assign out_take      = m_axis_tvalid && m_axis_tready;
    // Take a new byte once the buffer is empty or its last entry leaves now.
    assign s_axis_tready = (out_cnt_reg == 2'd0) || ((out_cnt_reg == 2'd1) && m_axis_tready);
    assign in_take       = s_axis_tvalid && s_axis_tready;

    assign m_axis_tdata = {{(24-CP_W){1'b0}}, slot_reg[0].code_point};
    assign m_axis_tuser = slot_reg[0].bad_sequence;
    assign m_axis_tlast = slot_reg[0].run_last;

    // Decode the incoming byte against the open sequence.
    always_comb
    begin
        need_next     = need_reg;
        part_next     = part_reg;
        held1_next    = held1_reg;
        held_cnt_next = held_cnt_reg;
        res_n         = 2'd0;
        for (int i = 0; i < 3; i++)
        begin
            res[i] = '0;
        end

        if (need_reg == 2'd0)
        begin
            priority if (b < ASCII_LIMIT)
            begin
                res[0] = single_byte(b);
                res_n  = 2'd1;
            end
            else if ((lead.extra == 2'd0) || eot)
            begin
                res[0].bad_sequence = 1'b1;
                res_n = 2'd1;
            end
            else
            begin
                // Open a sequence.
                need_next     = lead.extra;
                part_next     = lead.bits;
                held_cnt_next = 2'd1;
            end
        end
        else
        begin
            part_next = pv;
            need_next = nd;
            priority if (nd == 2'd0)
            begin
                res[0].code_point = pv;
                res_n         = 2'd1;
                need_next     = 2'd0;
                part_next     = '0;
                held_cnt_next = 2'd0;
            end
            else if (eot)
            begin
                // Cut-off sequence: the lead is bad, then re-decode the rest.
                res[0].bad_sequence = 1'b1;
                if (held_cnt_reg < 2'd2)
                begin
                    res[1] = single_byte(b);
                    res_n  = 2'd2;
                end
                else
                begin
                    priority if (held1_reg < ASCII_LIMIT)
                    begin
                        res[1] = single_byte(held1_reg);
                        res[2] = single_byte(b);
                        res_n  = 2'd3;
                    end
                    else if (lead1.extra == 2'd1)
                    begin
                        res[1].code_point = shift_in(lead1.bits, b);
                        res_n = 2'd2;
                    end
                    else
                    begin
                        res[1].bad_sequence = 1'b1;
                        res[2] = single_byte(b);
                        res_n  = 2'd3;
                    end
                end
            end
            else
            begin
                // Hold the following byte; only the first one is read back.
                if (held_cnt_reg == 2'd1)
                begin
                    held1_next = b;
                end
                if (held_cnt_reg != 2'd3)
                begin
                    held_cnt_next = held_cnt_reg + 2'd1;
                end
            end
        end

        if (eot)
        begin
            need_next     = 2'd0;
            part_next     = '0;
            held_cnt_next = 2'd0;
        end

        // Mark the last result of this byte.
        unique case (res_n)
            2'd1:    res[0].run_last = 1'b1;
            2'd2:    res[1].run_last = 1'b1;
            2'd3:    res[2].run_last = 1'b1;
            default: ;
        endcase
    end

    // Load new results or advance the buffer by one.
    always_comb
    begin
        out_cnt_next = out_cnt_reg;
        for (int i = 0; i < 3; i++)
        begin
            slot_next[i] = slot_reg[i];
        end
        if (in_take)
        begin
            out_cnt_next = res_n;
            for (int i = 0; i < 3; i++)
            begin
                slot_next[i] = res[i];
            end
        end
        else if (out_take)
        begin
            out_cnt_next = out_cnt_reg - 2'd1;
            slot_next[0] = slot_reg[1];
            slot_next[1] = slot_reg[2];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            need_reg     <= 2'd0;
            part_reg     <= '0;
            held_cnt_reg <= 2'd0;
            out_cnt_reg  <= 2'd0;
        end
        else
        begin
            out_cnt_reg <= out_cnt_next;
            if (in_take)
            begin
                need_reg     <= need_next;
                part_reg     <= part_next;
                held_cnt_reg <= held_cnt_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            held1_reg <= held1_next;
        end
        for (int i = 0; i < 3; i++)
        begin
            slot_reg[i] <= slot_next[i];
        end
    end

endmodule

// ===== tb/utf8_stream_decoder_unit_tb.sv =====
// Self-checking testbench for the UTF-8 stream decoder: directed table, random texts, scoreboard.
module utf8_stream_decoder_unit_tb
    import utf8_pkg::*;
();

    localparam int CYCLE_LIMIT   = 100000;
    localparam int RANDOM_ITEMS  = 355;
    localparam int DIRECTED_ROWS = 25;
    localparam int TAIL_CYCLES   = 8;

    // One row of the directed table. Where typed_ok is set, the row causes
    // exactly one result and cp/bad hold it; other rows go to the predictor.
    typedef struct packed {
        logic [7:0]      text_b;
        logic            eot;
        logic            typed_ok;
        logic [CP_W-1:0] cp;
        logic            bad;
    } stim_row_t;

    localparam stim_row_t [0:DIRECTED_ROWS-1] DIRECTED = {
        // extremes of the ASCII range pass straight through
        {8'h00, 1'b0, 1'b1, 21'h000000, 1'b0},
        {8'h7F, 1'b0, 1'b1, 21'h00007F, 1'b0},
        // stray following byte and invalid lead
        {8'h80, 1'b0, 1'b1, 21'h000000, 1'b1},
        {8'hFF, 1'b0, 1'b1, 21'h000000, 1'b1},
        // two-byte sequence
        {8'hC3, 1'b0, 1'b0, 21'h000000, 1'b0},
        {8'hA9, 1'b0, 1'b0, 21'h000000, 1'b0},
        // lead on the final byte of a text
        {8'hC2, 1'b1, 1'b1, 21'h000000, 1'b1},
        // three-byte sequence
        {8'hE2, 1'b0, 1'b0, 21'h000000, 1'b0},
        {8'h82, 1'b0, 1'b0, 21'h000000, 1'b0},
        {8'hAC, 1'b0, 1'b0, 21'h000000, 1'b0},
        // four-byte sequence with all payload bits set
        {8'hF7, 1'b0, 1'b0, 21'h000000, 1'b0},
        {8'hBF, 1'b0, 1'b0, 21'h000000, 1'b0},
        {8'hBF, 1'b0, 1'b0, 21'h000000, 1'b0},
        {8'hBF, 1'b0, 1'b0, 21'h000000, 1'b0},
        // cut off: ASCII final byte decoded again
        {8'hE2, 1'b0, 1'b0, 21'h000000, 1'b0},
        {8'h41, 1'b1, 1'b0, 21'h000000, 1'b0},
        // cut off: held byte and final byte form a complete two-byte sequence
        {8'hF0, 1'b0, 1'b0, 21'h000000, 1'b0},
        {8'hC3, 1'b0, 1'b0, 21'h000000, 1'b0},
        {8'hA9, 1'b1, 1'b0, 21'h000000, 1'b0},
        // cut off: three results, all bad
        {8'hF0, 1'b0, 1'b0, 21'h000000, 1'b0},
        {8'h80, 1'b0, 1'b0, 21'h000000, 1'b0},
        {8'hFF, 1'b1, 1'b0, 21'h000000, 1'b0},
        // cut off: final byte is itself a lead that cannot complete
        {8'hE0, 1'b0, 1'b0, 21'h000000, 1'b0},
        {8'hE1, 1'b1, 1'b0, 21'h000000, 1'b0},
        // plain ASCII as the final byte
        {8'h41, 1'b1, 1'b1, 21'h000041, 1'b0}
    };

    logic        clk           = 1'b0;
    logic        rst_n         = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata  = 8'h00;    // [7:0] text_byte
    logic        s_axis_tlast  = 1'b0;     // end_of_text
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;             // [20:0] code_point, [23:21] zero
    logic        m_axis_tuser;             // [0] bad_sequence
    logic        m_axis_tlast;             // run_last

    // Decoder state as the predictor tracks it.
    logic [1:0]      need_cnt;
    logic [CP_W-1:0] acc_cp;
    logic [7:0]      held_bytes [3];
    int              held_n;

    res_t step_res_q [$];      // results of the byte just taken
    res_t cp_expect_q [$];     // decoded code points still awaited

    int cycle_cnt    = 0;
    int mismatch_cnt = 0;
    int items_sent   = 0;
    int texts_sent   = 0;
    int cutoff_texts = 0;
    int results_seen = 0;
    int bad_seen     = 0;
    logic tx_calm    = 1'b0;
    logic rx_calm    = 1'b0;

    utf8_stream_decoder_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles, %0d results still awaited",
                     cycle_cnt, cp_expect_q.size());
            $display("utf8_stream_decoder_unit test failed");
            $finish;
        end
    end

    // Number of following bytes a lead asks for (0 if not a lead) and its payload.
    function automatic int lead_extra(input logic [7:0] b, output logic [CP_W-1:0] payload);
        casez (b)
            8'b110?????:
            begin
                payload = {16'b0, b[4:0]};
                return 1;
            end
            8'b1110????:
            begin
                payload = {17'b0, b[3:0]};
                return 2;
            end
            8'b11110???:
            begin
                payload = {18'b0, b[2:0]};
                return 3;
            end
            default:
            begin
                payload = '0;
                return 0;
            end
        endcase
    endfunction

    function automatic res_t make_res(input logic [CP_W-1:0] cp, input logic bad);
        res_t r;
        r.code_point   = cp;
        r.bad_sequence = bad;
        r.run_last     = 1'b0;
        return r;
    endfunction

    task automatic clear_decode();
        need_cnt = 2'd0;
        acc_cp   = '0;
        held_n   = 0;
    endtask

    // Advance the predicted decoder by one text byte; leave its results in step_res_q.
    task automatic predict_byte(input logic [7:0] b, input logic eot);
        logic [CP_W-1:0] payload;
        logic [7:0]      tail_bytes [3];
        int              tail_len;
        int              extra;
        int              i;
        int              k;
        step_res_q.delete();
        if (need_cnt == 2'd0)
        begin
            extra = lead_extra(b, payload);
            if (b < 8'h80)
                step_res_q.insert(step_res_q.size(), make_res({13'b0, b}, 1'b0));
            else if (extra == 0 || eot)
                step_res_q.insert(step_res_q.size(), make_res('0, 1'b1));
            else
            begin
                need_cnt      = extra[1:0];
                acc_cp        = payload;
                held_bytes[0] = b;
                held_n        = 1;
            end
        end
        else
        begin
            acc_cp   = {acc_cp[CP_W-7:0], b[5:0]};
            need_cnt = need_cnt - 2'd1;
            if (need_cnt == 2'd0)
            begin
                step_res_q.insert(step_res_q.size(), make_res(acc_cp, 1'b0));
                clear_decode();
            end
            else if (eot)
            begin
                // Cut off: decode the held bytes plus this one again as a text of their own.
                tail_len = 0;
                for (k = 0; k < held_n && k < 2; k++)
                begin
                    tail_bytes[tail_len] = held_bytes[k];
                    tail_len++;
                end
                tail_bytes[tail_len] = b;
                tail_len++;
                i = 0;
                while (i < tail_len && step_res_q.size() < 3)
                begin
                    if (tail_bytes[i] < 8'h80)
                    begin
                        step_res_q.insert(step_res_q.size(),
                                          make_res({13'b0, tail_bytes[i]}, 1'b0));
                        i++;
                    end
                    else
                    begin
                        extra = lead_extra(tail_bytes[i], payload);
                        if (extra == 0 || i + extra >= tail_len)
                        begin
                            step_res_q.insert(step_res_q.size(), make_res('0, 1'b1));
                            i++;
                        end
                        else
                        begin
                            for (k = 1; k <= extra; k++)
                                payload = {payload[CP_W-7:0], tail_bytes[i+k][5:0]};
                            step_res_q.insert(step_res_q.size(), make_res(payload, 1'b0));
                            i += extra + 1;
                        end
                    end
                end
            end
            else if (held_n < 3)
            begin
                held_bytes[held_n] = b;
                held_n++;
            end
        end
        if (eot)
            clear_decode();
        if (step_res_q.size() > 0)
            step_res_q[step_res_q.size() - 1].run_last = 1'b1;
    endtask

    function automatic int pick_wait(input logic calm);
        return calm ? 0 : $urandom_range(0, 8);
    endfunction

    // Offer one text byte, hold it until taken, then book its expected results.
    task automatic send_item(input logic [7:0] b, input logic eot,
                             input logic use_typed, input res_t typed);
        int gap;
        if ($urandom_range(0, 23) == 0)
            tx_calm = ~tx_calm;
        gap = pick_wait(tx_calm);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= eot;
        do
            @(posedge clk);
        while (!s_axis_tready);
        predict_byte(b, eot);
        if (use_typed)
            cp_expect_q.insert(cp_expect_q.size(), typed);
        else
            foreach (step_res_q[i])
                cp_expect_q.insert(cp_expect_q.size(), step_res_q[i]);
        items_sent++;
    endtask

    // Drop valid and hold off until every awaited result has drained.
    task automatic wait_for_drain();
        s_axis_tvalid <= 1'b0;
        while (cp_expect_q.size() != 0)
            @(posedge clk);
    endtask

    function automatic logic [7:0] follow_byte();
        return ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255))
                                           : {2'b10, 6'($urandom_range(0, 63))};
    endfunction

    // Byte for the inside of a cut-off sequence: any class, so the replay sees all of them.
    function automatic logic [7:0] mixed_byte();
        case ($urandom_range(0, 4))
            0: return 8'($urandom_range(0, 127));
            1: return {3'b110, 5'($urandom_range(0, 31))};
            2: return {2'b10, 6'($urandom_range(0, 63))};
            3: return {4'b1110, 4'($urandom_range(0, 15))};
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // Build one text of mostly well-formed characters, sometimes cut off at its end.
    task automatic send_random_text();
        logic [7:0] txt [$];
        logic [7:0] lead;
        int         n_chars;
        int         extra;
        int         cut_len;
        int         c;
        int         k;
        res_t       none;
        none    = '0;
        n_chars = $urandom_range(1, 8);
        for (c = 0; c < n_chars; c++)
        begin
            extra = 0;
            case ($urandom_range(0, 9))
                0, 1, 2, 3: txt.insert(txt.size(), 8'($urandom_range(0, 127)));
                4:
                begin
                    lead  = {3'b110, 5'($urandom_range(0, 31))};
                    extra = 1;
                end
                5:
                begin
                    lead  = {4'b1110, 4'($urandom_range(0, 15))};
                    extra = 2;
                end
                6, 7:
                begin
                    lead  = {5'b11110, 3'($urandom_range(0, 7))};
                    extra = 3;
                end
                8: txt.insert(txt.size(),
                              $urandom_range(0, 1) ? {2'b10, 6'($urandom_range(0, 63))}
                                                   : {5'b11111, 3'($urandom_range(0, 7))});
                default: txt.insert(txt.size(), 8'($urandom_range(0, 255)));
            endcase
            if (extra > 0)
            begin
                txt.insert(txt.size(), lead);
                for (k = 0; k < extra; k++)
                    txt.insert(txt.size(), follow_byte());
            end
        end
        if ($urandom_range(0, 2) == 0)
        begin
            extra = $urandom_range(1, 3);
            case (extra)
                1: lead = {3'b110, 5'($urandom_range(0, 31))};
                2: lead = {4'b1110, 4'($urandom_range(0, 15))};
                default: lead = {5'b11110, 3'($urandom_range(0, 7))};
            endcase
            cut_len = $urandom_range(0, extra - 1);
            txt.insert(txt.size(), lead);
            for (k = 0; k < cut_len; k++)
                txt.insert(txt.size(), mixed_byte());
            cutoff_texts++;
        end
        for (k = 0; k < txt.size(); k++)
            send_item(txt[k], k == txt.size() - 1, 1'b0, none);
        texts_sent++;
    endtask

    task automatic report_mismatch(input string what);
        mismatch_cnt++;
        if (mismatch_cnt <= 10)
            $display("MISMATCH: %s", what);
    endtask

    // Compare a result taken from the decoder with the oldest expectation.
    task automatic check_result();
        res_t want;
        if (cp_expect_q.size() == 0)
            report_mismatch($sformatf("result with nothing awaited: tdata=%h bad=%b last=%b",
                                      m_axis_tdata, m_axis_tuser, m_axis_tlast));
        else
        begin
            want = cp_expect_q.pop_front();
            if (m_axis_tdata !== {3'b000, want.code_point} ||
                m_axis_tuser !== want.bad_sequence || m_axis_tlast !== want.run_last)
                report_mismatch($sformatf(
                    "result %0d: want cp=%h bad=%b last=%b, got tdata=%h bad=%b last=%b",
                    results_seen, want.code_point, want.bad_sequence, want.run_last,
                    m_axis_tdata, m_axis_tuser, m_axis_tlast));
            if (want.bad_sequence)
                bad_seen++;
        end
        results_seen++;
    endtask

    // Result side: stall at random, take every offered result and check it.
    initial
    begin : result_sink
        int stall;
        while (rst_n !== 1'b1)
            @(posedge clk);
        forever
        begin
            if ($urandom_range(0, 23) == 0)
                rx_calm = ~rx_calm;
            stall = pick_wait(rx_calm);
            if (stall > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            do
                @(posedge clk);
            while (!m_axis_tvalid);
            check_result();
        end
    end

    initial
    begin : text_source
        stim_row_t row;
        res_t      typed;
        int        row_i;
        clear_decode();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table first; typed rows carry their own answer.
        for (row_i = 0; row_i < DIRECTED_ROWS; row_i++)
        begin
            row                = DIRECTED[row_i];
            typed.code_point   = row.cp;
            typed.bad_sequence = row.bad;
            typed.run_last     = 1'b1;
            send_item(row.text_b, row.eot, row.typed_ok, typed);
        end
        wait_for_drain();

        // Random texts, with an occasional full drain between them.
        while (items_sent < DIRECTED_ROWS + RANDOM_ITEMS)
        begin
            send_random_text();
            if ($urandom_range(0, 11) == 0)
                wait_for_drain();
        end
        s_axis_tvalid <= 1'b0;

        while (cp_expect_q.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (cp_expect_q.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", cp_expect_q.size()));

        $display("Decoded %0d text bytes in %0d random texts plus the directed table,",
                 items_sent, texts_sent);
        $display("%0d texts cut off mid-sequence; %0d results checked, %0d marked bad.",
                 cutoff_texts, results_seen, bad_seen);
        if (mismatch_cnt == 0)
            $display("utf8_stream_decoder_unit test passed");
        else
        begin
            $display("%0d mismatches in total", mismatch_cnt);
            $display("utf8_stream_decoder_unit test failed");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/utf8_pkg.sv
rtl/utf8_stream_decoder_unit.sv
tb/utf8_stream_decoder_unit_tb.sv
